[hw/rtl/lsim_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsim_pkg
// shared widths, register codes, pipeline item type and helpers for the
// lattice shell index mapper
// ----------------------------------------------------------------------------
package lsim_pkg;

   localparam int MAX_DIM = 1024;
   localparam int CNT_W   = 11;  // sample counts and field sizes, up to 1024
   localparam int COORD_W = 10;  // lattice and source coordinates
   localparam int TOT_W   = 23;  // shell sizes and partial products
   localparam int DIV_W   = 23;  // divider operand width, one cell per bit
   localparam int LANES   = 3;   // parallel divider lanes in every cell
   localparam int CSR_W   = 2;

   localparam logic [CSR_W-1:0] CSR_DIM_X  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_DIM_Y  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_DIM_Z  = 2'd2;
   localparam logic [CSR_W-1:0] CSR_STRIDE = 2'd3;

   localparam logic [1:0] REGION_Z = 2'd0;
   localparam logic [1:0] REGION_Y = 2'd1;
   localparam logic [1:0] REGION_X = 2'd2;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] quo;   // dividend in, quotient out
      logic [DIV_W-1:0] dvs;
   } lane_type;

   typedef struct packed {
      logic             vld;
      logic [DIV_W-1:0] idx;
      logic [CNT_W-1:0] dx;
      logic [CNT_W-1:0] dy;
      logic [CNT_W-1:0] dz;
      logic [CNT_W-1:0] cx;
      logic [CNT_W-1:0] cy;
      logic [CNT_W-1:0] cz;
      logic [TOT_W-1:0] pxy;
      logic [TOT_W-1:0] zf;
      logic [TOT_W-1:0] t1;
      logic [TOT_W-1:0] t2;
      logic [TOT_W-1:0] zyf;
      logic [TOT_W-1:0] total;
      logic             hit;
      logic [1:0]       region;
      logic [DIV_W-1:0] q1;
      logic [COORD_W-1:0] lx;
      logic [COORD_W-1:0] ly;
      logic [COORD_W-1:0] lz;
      lane_type [LANES-1:0] lane;
   } item_type;

   function automatic logic [CNT_W-1:0] inner_of(input logic [CNT_W-1:0] n);
      return (n > CNT_W'(2)) ? n - CNT_W'(2) : '0;
   endfunction

   function automatic logic [CNT_W-1:0] count_of(input logic [CNT_W-1:0] d,
                                                 input logic [DIV_W-1:0] q);
      logic [CNT_W-1:0] c;
      if (d <= CNT_W'(1)) begin
         c = d;
      end else if (q == '0) begin
         c = CNT_W'(2);
      end else begin
         c = q[CNT_W-1:0] + CNT_W'(1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/lsim_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsim_div_cell
// one restoring division step on every lane, registered
// ----------------------------------------------------------------------------
module lsim_div_cell import lsim_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire item_type cell_in,
   output item_type      cell_out
);

   item_type cell_ff;
   item_type cell_in_nxt;

   always_comb begin
      logic [DIV_W:0] sh;
      cell_in_nxt = cell_in;
      for (int k = 0; k < LANES; k++) begin
         sh = {cell_in.lane[k].rem, cell_in.lane[k].quo[DIV_W-1]};
         if (sh >= {1'b0, cell_in.lane[k].dvs}) begin
            sh = sh - {1'b0, cell_in.lane[k].dvs};
            cell_in_nxt.lane[k].quo = {cell_in.lane[k].quo[DIV_W-2:0], 1'b1};
         end else begin
            cell_in_nxt.lane[k].quo = {cell_in.lane[k].quo[DIV_W-2:0], 1'b0};
         end
         cell_in_nxt.lane[k].rem = sh[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else begin
         cell_ff <= cell_in_nxt;
      end
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

[hw/rtl/lsim_div_chain.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsim_div_chain
// row of division cells, one quotient bit per cell, one item per cycle
// ----------------------------------------------------------------------------
module lsim_div_chain import lsim_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire item_type chain_in,
   output item_type      chain_out
);

   item_type link [DIV_W+1];

   assign link[0] = chain_in;

   for (genvar i = 0; i < DIV_W; i++) begin : g_cell
      lsim_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (link[i]),
         .cell_out (link[i+1])
      );
   end

   assign chain_out = link[DIV_W];

endmodule
`default_nettype wire

[hw/rtl/lattice_shell_index_mapper.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lattice_shell_index_mapper
// maps a linear shell index of a subsampled box lattice to its coordinates
// ----------------------------------------------------------------------------
// pipeline: 101 register stages; four 23-cell divider chains make up most of them
// throughput: one item per cycle, busy is never raised
// results cannot be stalled, every result is shown for exactly one cycle
// reset: pipeline emptied, dimensions cleared to 0, stride set to 1
// ----------------------------------------------------------------------------
module lattice_shell_index_mapper import lsim_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [TOT_W-1:0]   req_shell_position,
   output logic                    rsp_strobe,
   output logic                    rsp_valid_res,
   output logic [COORD_W-1:0]      rsp_lattice_x,
   output logic [COORD_W-1:0]      rsp_lattice_y,
   output logic [COORD_W-1:0]      rsp_lattice_z,
   output logic [COORD_W-1:0]      rsp_source_x,
   output logic [COORD_W-1:0]      rsp_source_y,
   output logic [COORD_W-1:0]      rsp_source_z,
   output logic [5:0]              rsp_face_mask,
   output logic [TOT_W-1:0]        rsp_shell_total,
   input  wire logic               csr_we,
   input  wire logic [CSR_W-1:0]   csr_index,
   input  wire logic [CNT_W-1:0]   csr_wdata
);

   // configuration registers
   logic [CNT_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff, stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff  <= '0;
         dim_y_ff  <= '0;
         dim_z_ff  <= '0;
         stride_ff <= CNT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIM_X:  dim_x_ff  <= csr_wdata;
            CSR_DIM_Y:  dim_y_ff  <= csr_wdata;
            CSR_DIM_Z:  dim_z_ff  <= csr_wdata;
            CSR_STRIDE: stride_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // pipeline registers, chains in between
   item_type s0_in, s0_ff, a_out;
   item_type s1_in, s1_ff;
   item_type s2_in, s2_ff;
   item_type s3_in, s3_ff;
   item_type s4_in, s4_ff, b_out;
   item_type s5_in, s5_ff, c_out;
   item_type s6_in, s6_ff;
   item_type s7_in, s7_ff, d_out;

   // stage 0: saturate dims, load the sample count divisions (dim-1)/stride
   always_comb begin
      logic [LANES-1:0][CNT_W-1:0] dim;
      logic [CNT_W-1:0]            st;
      s0_in     = '0;
      s0_in.vld = start;
      s0_in.idx = req_shell_position;
      s0_in.dx  = (dim_x_ff > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : dim_x_ff;
      s0_in.dy  = (dim_y_ff > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : dim_y_ff;
      s0_in.dz  = (dim_z_ff > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : dim_z_ff;
      st        = (stride_ff == '0) ? CNT_W'(1) : stride_ff;
      dim[0]    = s0_in.dx;
      dim[1]    = s0_in.dy;
      dim[2]    = s0_in.dz;
      for (int k = 0; k < LANES; k++) begin
         s0_in.lane[k].rem = '0;
         s0_in.lane[k].quo = (dim[k] == '0) ? '0 : DIV_W'(dim[k] - CNT_W'(1));
         s0_in.lane[k].dvs = DIV_W'(st);
      end
   end

   lsim_div_chain u_chain_a (.clock(clock), .reset(reset), .chain_in(s0_ff),
                             .chain_out(a_out));

   // stage 1: sample counts per axis and the z face size
   always_comb begin
      s1_in     = a_out;
      s1_in.cx  = count_of(a_out.dx, a_out.lane[0].quo);
      s1_in.cy  = count_of(a_out.dy, a_out.lane[1].quo);
      s1_in.cz  = count_of(a_out.dz, a_out.lane[2].quo);
      s1_in.pxy = TOT_W'(s1_in.cx) * TOT_W'(s1_in.cy);
   end

   // stage 2: both z faces, interior products
   always_comb begin
      s2_in    = s1_ff;
      s2_in.zf = (s1_ff.cz > CNT_W'(1)) ? {s1_ff.pxy[TOT_W-2:0], 1'b0} : s1_ff.pxy;
      s2_in.t1 = TOT_W'(s1_ff.cx) * TOT_W'(inner_of(s1_ff.cz));
      s2_in.t2 = TOT_W'(inner_of(s1_ff.cy)) * TOT_W'(inner_of(s1_ff.cz));
   end

   // stage 3: y rows and x columns, shell total
   always_comb begin
      logic [TOT_W-1:0] yf, xf;
      s3_in = s2_ff;
      yf    = (s2_ff.cy > CNT_W'(1)) ? {s2_ff.t1[TOT_W-2:0], 1'b0} : s2_ff.t1;
      xf    = (s2_ff.cx > CNT_W'(1)) ? {s2_ff.t2[TOT_W-2:0], 1'b0} : s2_ff.t2;
      s3_in.zyf = s2_ff.zf + yf;
      if (s2_ff.cx == '0 || s2_ff.cy == '0 || s2_ff.cz == '0) begin
         s3_in.total = '0;
      end else begin
         s3_in.total = s2_ff.zf + yf + xf;
      end
   end

   // stage 4: range check, pick the shell region, load the layer division
   always_comb begin
      s4_in     = s3_ff;
      s4_in.hit = s3_ff.idx < s3_ff.total;
      s4_in.lane[0].rem = '0;
      priority if (s3_ff.idx < s3_ff.zf) begin
         s4_in.region      = REGION_Z;
         s4_in.lane[0].quo = s3_ff.idx;
         s4_in.lane[0].dvs = s3_ff.pxy;
      end else if (s3_ff.idx < s3_ff.zyf) begin
         s4_in.region      = REGION_Y;
         s4_in.lane[0].quo = s3_ff.idx - s3_ff.zf;
         s4_in.lane[0].dvs = (s3_ff.cy > CNT_W'(1)) ? DIV_W'({s3_ff.cx, 1'b0})
                                                    : DIV_W'(s3_ff.cx);
      end else begin
         // x columns: one or two cells per interior row
         s4_in.region      = REGION_X;
         s4_in.lane[0].quo = s3_ff.idx - s3_ff.zyf;
         s4_in.lane[0].dvs = (s3_ff.cx > CNT_W'(1))
                              ? DIV_W'({inner_of(s3_ff.cy), 1'b0})
                              : DIV_W'(inner_of(s3_ff.cy));
      end
   end

   lsim_div_chain u_chain_b (.clock(clock), .reset(reset), .chain_in(s4_ff),
                             .chain_out(b_out));

   // stage 5: keep layer, split the remainder within the layer
   always_comb begin
      s5_in             = b_out;
      s5_in.q1          = b_out.lane[0].quo;
      s5_in.lane[0].rem = '0;
      s5_in.lane[0].quo = b_out.lane[0].rem;
      if (b_out.region == REGION_X) begin
         s5_in.lane[0].dvs = (b_out.cx > CNT_W'(1)) ? DIV_W'(2) : DIV_W'(1);
      end else begin
         s5_in.lane[0].dvs = DIV_W'(b_out.cx);
      end
   end

   lsim_div_chain u_chain_c (.clock(clock), .reset(reset), .chain_in(s5_ff),
                             .chain_out(c_out));

   // stage 6: lattice coordinates from layer, row and cell
   always_comb begin
      logic [DIV_W-1:0] q2, r2;
      s6_in = c_out;
      q2    = c_out.lane[0].quo;
      r2    = c_out.lane[0].rem;
      unique case (c_out.region)
         REGION_Z: begin
            s6_in.lx = r2[COORD_W-1:0];
            s6_in.ly = q2[COORD_W-1:0];
            s6_in.lz = (c_out.q1 != '0) ? COORD_W'(c_out.cz - CNT_W'(1)) : '0;
         end
         REGION_Y: begin
            s6_in.lx = r2[COORD_W-1:0];
            s6_in.ly = (q2 != '0) ? COORD_W'(c_out.cy - CNT_W'(1)) : '0;
            s6_in.lz = c_out.q1[COORD_W-1:0] + COORD_W'(1);
         end
         default: begin
            s6_in.lx = (r2 != '0) ? COORD_W'(c_out.cx - CNT_W'(1)) : '0;
            s6_in.ly = q2[COORD_W-1:0] + COORD_W'(1);
            s6_in.lz = c_out.q1[COORD_W-1:0] + COORD_W'(1);
         end
      endcase
   end

   // stage 7: load source rounding, (s*(dim-1) + (n-1)/2) / (n-1)
   always_comb begin
      logic [LANES-1:0][COORD_W-1:0] crd;
      logic [LANES-1:0][CNT_W-1:0]   cnt, dim;
      logic [CNT_W-1:0]              iv, dm1;
      s7_in  = s6_ff;
      crd[0] = s6_ff.lx;
      crd[1] = s6_ff.ly;
      crd[2] = s6_ff.lz;
      cnt[0] = s6_ff.cx;
      cnt[1] = s6_ff.cy;
      cnt[2] = s6_ff.cz;
      dim[0] = s6_ff.dx;
      dim[1] = s6_ff.dy;
      dim[2] = s6_ff.dz;
      for (int k = 0; k < LANES; k++) begin
         iv  = cnt[k] - CNT_W'(1);
         dm1 = dim[k] - CNT_W'(1);
         s7_in.lane[k].rem = '0;
         if (dim[k] <= CNT_W'(1) || cnt[k] <= CNT_W'(1)) begin
            // degenerate axis gives source 0
            s7_in.lane[k].quo = '0;
            s7_in.lane[k].dvs = DIV_W'(1);
         end else begin
            s7_in.lane[k].quo = DIV_W'(crd[k]) * DIV_W'(dm1) + DIV_W'(iv >> 1);
            s7_in.lane[k].dvs = DIV_W'(iv);
         end
      end
   end

   lsim_div_chain u_chain_d (.clock(clock), .reset(reset), .chain_in(s7_ff),
                             .chain_out(d_out));

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld <= 1'b0;
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0;
         s4_ff.vld <= 1'b0;
         s5_ff.vld <= 1'b0;
         s6_ff.vld <= 1'b0;
         s7_ff.vld <= 1'b0;
      end else begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   // output stage: face mask, zero everything for an out of range index
   logic               strobe_ff;
   logic               vres_ff, vres_in;
   logic [COORD_W-1:0] lx_ff, ly_ff, lz_ff, lx_in, ly_in, lz_in;
   logic [COORD_W-1:0] sx_ff, sy_ff, sz_ff, sx_in, sy_in, sz_in;
   logic [5:0]         mask_ff, mask_in;
   logic [TOT_W-1:0]   total_ff, total_in;

   always_comb begin
      vres_in  = d_out.hit;
      lx_in    = '0;
      ly_in    = '0;
      lz_in    = '0;
      sx_in    = '0;
      sy_in    = '0;
      sz_in    = '0;
      mask_in  = '0;
      total_in = '0;
      if (d_out.hit) begin
         lx_in      = d_out.lx;
         ly_in      = d_out.ly;
         lz_in      = d_out.lz;
         sx_in      = d_out.lane[0].quo[COORD_W-1:0];
         sy_in      = d_out.lane[1].quo[COORD_W-1:0];
         sz_in      = d_out.lane[2].quo[COORD_W-1:0];
         total_in   = d_out.total;
         mask_in[0] = d_out.lx == '0;
         mask_in[1] = CNT_W'(d_out.lx) + CNT_W'(1) == d_out.cx;
         mask_in[2] = d_out.ly == '0;
         mask_in[3] = CNT_W'(d_out.ly) + CNT_W'(1) == d_out.cy;
         mask_in[4] = d_out.lz == '0;
         mask_in[5] = CNT_W'(d_out.lz) + CNT_W'(1) == d_out.cz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= d_out.vld;
      end
   end

   always_ff @(posedge clock) begin
      vres_ff  <= vres_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
      lz_ff    <= lz_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      sz_ff    <= sz_in;
      mask_ff  <= mask_in;
      total_ff <= total_in;
   end

   assign busy            = 1'b0;
   assign rsp_strobe      = strobe_ff;
   assign rsp_valid_res   = vres_ff;
   assign rsp_lattice_x   = lx_ff;
   assign rsp_lattice_y   = ly_ff;
   assign rsp_lattice_z   = lz_ff;
   assign rsp_source_x    = sx_ff;
   assign rsp_source_y    = sy_ff;
   assign rsp_source_z    = sz_ff;
   assign rsp_face_mask   = mask_ff;
   assign rsp_shell_total = total_ff;

endmodule
`default_nettype wire

[hw/rtl/lsim_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsim_checker
// port level checks on the shell index mapper
// ----------------------------------------------------------------------------
module lsim_checker import lsim_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               busy,
   input wire logic               rsp_strobe,
   input wire logic               rsp_valid_res,
   input wire logic [COORD_W-1:0] rsp_lattice_x,
   input wire logic [COORD_W-1:0] rsp_lattice_y,
   input wire logic [COORD_W-1:0] rsp_lattice_z,
   input wire logic [COORD_W-1:0] rsp_source_x,
   input wire logic [COORD_W-1:0] rsp_source_y,
   input wire logic [COORD_W-1:0] rsp_source_z,
   input wire logic [5:0]         rsp_face_mask,
   input wire logic [TOT_W-1:0]   rsp_shell_total
);

   // pipeline empties on reset
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // one item per cycle, the input side is never stalled
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // out of range items carry all zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_valid_res |->
         rsp_lattice_x == '0 && rsp_lattice_y == '0 && rsp_lattice_z == '0 &&
         rsp_source_x == '0 && rsp_source_y == '0 && rsp_source_z == '0 &&
         rsp_face_mask == '0 && rsp_shell_total == '0)
      else $error("invalid item with nonzero fields");

   // a shell sample always lies on some face
   a_face_set: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_valid_res |-> rsp_face_mask != '0)
      else $error("valid item with empty face mask");

   // a valid item implies a nonempty shell
   a_total_set: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_valid_res |-> rsp_shell_total != '0)
      else $error("valid item with zero shell total");

endmodule

bind lattice_shell_index_mapper lsim_checker u_lsim_checker (.*);
`default_nettype wire

[tb/lattice_shell_index_mapper_test.sv]
// ----------------------------------------------------------------------------
// lattice_shell_index_mapper_test
// self-checking bench for the shell index mapper: a scoreboard class predicts
// every result from its own copy of the registers, random and directed items
// are pushed through several register settings, the random ones under three idle mixes
// ----------------------------------------------------------------------------
module lattice_shell_index_mapper_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lsim_pkg::*;

   // one mapped shell sample as seen on the rsp_ ports
   typedef struct packed {
      logic               valid_res;
      logic [COORD_W-1:0] lattice_x;
      logic [COORD_W-1:0] lattice_y;
      logic [COORD_W-1:0] lattice_z;
      logic [COORD_W-1:0] source_x;
      logic [COORD_W-1:0] source_y;
      logic [COORD_W-1:0] source_z;
      logic [5:0]         face_mask;
      logic [TOT_W-1:0]   shell_total;
   } shell_sample_type;

   class shell_scoreboard;
      bit [CNT_W-1:0]    dim_x, dim_y, dim_z, stride;
      shell_sample_type  pending[$];
      int                errors;

      function new();
         dim_x = 0; dim_y = 0; dim_z = 0; stride = 1; errors = 0;
      endfunction

      function void write_reg(logic [CSR_W-1:0] idx, bit [CNT_W-1:0] v);
         case (idx)
            CSR_DIM_X:  dim_x = v;
            CSR_DIM_Y:  dim_y = v;
            CSR_DIM_Z:  dim_z = v;
            CSR_STRIDE: stride = v;
            default:    ;
         endcase
      endfunction

      // field size after saturation to the largest supported dimension
      function longint unsigned clamp_dim(bit [CNT_W-1:0] d);
         return (d > MAX_DIM) ? MAX_DIM : d;
      endfunction

      function longint unsigned axis_count(longint unsigned d);
         longint unsigned st, n;
         st = (stride == 0) ? 1 : stride;
         if (d <= 1) return d;
         n = 1 + (d - 1) / st;
         return (n < 2) ? 2 : n;
      endfunction

      function longint unsigned two_or_one(longint unsigned n);
         return (n > 1) ? 2 : 1;
      endfunction

      function longint unsigned interior(longint unsigned n);
         return (n > 2) ? n - 2 : 0;
      endfunction

      // rounded field coordinate, halves go up
      function longint unsigned field_coord(longint unsigned s, longint unsigned n,
                                            longint unsigned d);
         if (d <= 1 || n <= 1) return 0;
         if (s >= n) s = n - 1;
         return (s * (d - 1) + (n - 1) / 2) / (n - 1);
      endfunction

      function longint unsigned shell_size();
         longint unsigned cx, cy, cz, t;
         cx = axis_count(clamp_dim(dim_x));
         cy = axis_count(clamp_dim(dim_y));
         cz = axis_count(clamp_dim(dim_z));
         if (cx == 0 || cy == 0 || cz == 0) return 0;
         t = cx * cy * two_or_one(cz) + cx * interior(cz) * two_or_one(cy)
           + interior(cy) * interior(cz) * two_or_one(cx);
         return (t > 64'hFFFF_FFFF) ? 0 : t;
      endfunction

      function void note_input(bit [TOT_W-1:0] pos);
         longint unsigned dx, dy, dz, cx, cy, cz, total, idx, zf, yf, ls, li;
         longint unsigned x, y, z;
         bit [5:0] m;
         shell_sample_type r;
         r = '0;
         dx = clamp_dim(dim_x); dy = clamp_dim(dim_y); dz = clamp_dim(dim_z);
         cx = axis_count(dx); cy = axis_count(dy); cz = axis_count(dz);
         total = shell_size();
         idx = pos;
         x = 0; y = 0; z = 0; m = 0;
         if (idx < total) begin
            zf = cx * cy * two_or_one(cz);
            yf = cx * interior(cz) * two_or_one(cy);
            r.valid_res = 1;
            if (idx < zf) begin
               // bottom and top z faces
               li = idx % (cx * cy);
               x = li % cx;
               y = li / cx;
               if (idx / (cx * cy) != 0) z = cz - 1;
            end else if (idx - zf < yf) begin
               // front and back rows of each interior layer
               idx = idx - zf;
               ls = cx * two_or_one(cy);
               li = idx % ls;
               z = idx / ls + 1;
               x = li % cx;
               if (li / cx != 0) y = cy - 1;
            end else begin
               // left and right cells of interior rows
               idx = idx - zf - yf;
               ls = interior(cy) * two_or_one(cx);
               if (ls == 0) r.valid_res = 0;
               else begin
                  li = idx % ls;
                  z = idx / ls + 1;
                  y = li / two_or_one(cx) + 1;
                  if (li % two_or_one(cx) != 0) x = cx - 1;
               end
            end
            if (r.valid_res) begin
               if (x == 0) m[0] = 1;
               if (x + 1 == cx) m[1] = 1;
               if (y == 0) m[2] = 1;
               if (y + 1 == cy) m[3] = 1;
               if (z == 0) m[4] = 1;
               if (z + 1 == cz) m[5] = 1;
               r.lattice_x = x[COORD_W-1:0];
               r.lattice_y = y[COORD_W-1:0];
               r.lattice_z = z[COORD_W-1:0];
               r.source_x = COORD_W'(field_coord(x, cx, dx));
               r.source_y = COORD_W'(field_coord(y, cy, dy));
               r.source_z = COORD_W'(field_coord(z, cz, dz));
               r.face_mask = m;
               r.shell_total = total[TOT_W-1:0];
            end
         end
         pending.push_back(r);
      endfunction

      function void check_result(shell_sample_type act);
         shell_sample_type exp_r;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %p", $time, act);
            return;
         end
         exp_r = pending.pop_front();
         if (act !== exp_r) begin
            errors++;
            $display("%0t: result differs, expected %p, actual %p", $time, exp_r, act);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [TOT_W-1:0]   req_shell_position;
   logic               rsp_strobe;
   logic               rsp_valid_res;
   logic [COORD_W-1:0] rsp_lattice_x, rsp_lattice_y, rsp_lattice_z;
   logic [COORD_W-1:0] rsp_source_x, rsp_source_y, rsp_source_z;
   logic [5:0]         rsp_face_mask;
   logic [TOT_W-1:0]   rsp_shell_total;
   logic               csr_we;
   logic [CSR_W-1:0]   csr_index;
   logic [CNT_W-1:0]   csr_wdata;

   shell_scoreboard sb = new();
   int idle_pct;

   lattice_shell_index_mapper u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_shell_position(req_shell_position),
      .rsp_strobe(rsp_strobe), .rsp_valid_res(rsp_valid_res),
      .rsp_lattice_x(rsp_lattice_x), .rsp_lattice_y(rsp_lattice_y),
      .rsp_lattice_z(rsp_lattice_z), .rsp_source_x(rsp_source_x),
      .rsp_source_y(rsp_source_y), .rsp_source_z(rsp_source_z),
      .rsp_face_mask(rsp_face_mask), .rsp_shell_total(rsp_shell_total),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // results cannot be held off, so every strobe is checked at its closing edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_result({rsp_valid_res, rsp_lattice_x, rsp_lattice_y, rsp_lattice_z,
                          rsp_source_x, rsp_source_y, rsp_source_z, rsp_face_mask,
                          rsp_shell_total});
      end
   end

   // hold start until an accept edge, then let the scoreboard know;
   // idle cycles follow with the chance given by idle_pct for each cycle
   task automatic push_item(bit [TOT_W-1:0] pos);
      start <= 1'b1;
      req_shell_position <= pos;
      do @(posedge clock); while (busy);
      sb.note_input(pos);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // drain the pipeline fully, then pause for the latency before a write
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (110) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_W-1:0] idx, bit [CNT_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic set_lattice(bit [CNT_W-1:0] x, y, z, st);
      drain();
      write_reg(CSR_DIM_X, x);
      write_reg(CSR_DIM_Y, y);
      write_reg(CSR_DIM_Z, z);
      write_reg(CSR_STRIDE, st);
      csr_we <= 1'b0;
   endtask

   // first, middle and last shell index, the largest possible index, plus the first index past the end
   task automatic directed_items();
      longint unsigned t;
      t = sb.shell_size();
      push_item('0);
      push_item(23'h7FFFFF);
      if (t > 0) begin
         push_item(TOT_W'(t - 1));
         push_item(TOT_W'(t / 2));
      end
      push_item(TOT_W'(t));
   endtask

   task automatic random_items(int n);
      longint unsigned t;
      int k;
      t = sb.shell_size();
      for (k = 0; k < n; k++) begin
         if (t > 0 && $urandom_range(99) < 85)
            push_item(TOT_W'($urandom_range(int'(t - 1))));
         else if ($urandom_range(1))
            push_item(TOT_W'($urandom));
         else
            push_item(TOT_W'(t + $urandom_range(3)));
      end
   endtask

   function automatic bit [CNT_W-1:0] pick_dim();
      case ($urandom_range(9))
         0:       return CNT_W'($urandom);
         1:       return CNT_W'($urandom_range(0, 2));
         default: return CNT_W'($urandom_range(1, 40));
      endcase
   endfunction

   initial begin
      int p;
      reset = 1'b1;
      start = 1'b0;
      req_shell_position = '0;
      csr_we = 1'b0;
      csr_index = CSR_DIM_X;
      csr_wdata = '0;
      idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: every dimension zero, nothing inside the shell
      directed_items();

      // single cell, saturated box, zero and huge strides, a box one sample deep in y
      set_lattice(1, 1, 1, 1);
      directed_items();
      set_lattice(11'h7FF, 11'h7FF, 11'h7FF, 1);
      directed_items();
      set_lattice(1024, 1024, 1024, 0);
      directed_items();
      set_lattice(1024, 700, 5, 1024);
      directed_items();
      set_lattice(2, 2, 2, 11'h7FF);
      directed_items();
      set_lattice(7, 1, 9, 3);
      directed_items();

      // random lattices under three idle mixes; the drain before each new
      // setting is where the sender waits for every outstanding result
      for (p = 0; p < 18; p++) begin
         idle_pct = (p < 6) ? 9 : (p < 12) ? 69 : 0;
         set_lattice(pick_dim(), pick_dim(), pick_dim(),
                     ($urandom_range(7) == 0) ? CNT_W'($urandom)
                                              : CNT_W'($urandom_range(0, 6)));
         random_items(95);
      end

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("lattice_shell_index_mapper: match");
      else
         $display("lattice_shell_index_mapper: mismatch");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("lattice_shell_index_mapper: mismatch");
      $finish;
   end

endmodule
